>>> hw/rtl/lfx_pkg.sv
// Shared types, register codes and period arithmetic for the LED light-effect generator.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package lfx_pkg;

    localparam int unsigned TICK_W   = 10;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned CH_W     = 8;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned SPEED_W  = 7;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned SEG_W    = 3;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;

    // Effect modes
    localparam logic [MODE_W-1:0] MODE_CONTINUOUS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLASH      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STROBE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FADE       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SMOOTH     = 3'd4;

    // Register indexes (word address)
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COLOR = 2'd1;
    localparam logic [1:0] REG_SPEED = 2'd2;

    // Fixed colors and periods
    localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hFF0000;
    localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COLOR_BLUE  = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
    localparam logic [TICK_W-1:0]  CONT_PERIOD = 10'd1000;
    localparam logic [SPEED_W-1:0] SPEED_STOP  = 7'd100;
    localparam logic [CH_W-1:0]    CH_MAX      = 8'hFF;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COLOR_W-1:0] base_color;
        logic [SPEED_W-1:0] speed;
    } t_cfg;

    // Effect state after one tick, plus the frame push flag
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CH_W-1:0]    fade_level;
        logic [CH_W-1:0]    wheel_red;
        logic [CH_W-1:0]    wheel_green;
        logic [CH_W-1:0]    wheel_blue;
        logic               refresh;
    } t_frame;

    // Frame period in ticks, never below one.
    // Base period is 10*(100 - speed); divide by 50 as (100 - speed)/5 = x*205 >> 10.
    function automatic logic [TICK_W-1:0] frame_period(input t_cfg cfg);
        logic [SPEED_W-1:0] left;
        logic [TICK_W-1:0]  base;
        logic [14:0]        prod;
        logic [TICK_W-1:0]  p;
        left = (cfg.speed >= SPEED_STOP) ? '0 : SPEED_STOP - cfg.speed;
        base = {left, 3'b000} + {2'b00, left, 1'b0};
        prod = 15'(left) * 15'd205;
        case (cfg.mode)
            MODE_CONTINUOUS: p = CONT_PERIOD;
            MODE_FADE:       p = TICK_W'(prod[14:10]);
            MODE_SMOOTH:     p = {3'b000, base[TICK_W-1:3]};
            default:         p = base;
        endcase
        if (p == '0) begin
            p = TICK_W'(1);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lfx_ifs.sv
// Valid/ready channel interfaces for the tick input and the frame output.
// Depends on lfx_pkg for field widths.
`default_nettype none

interface lfx_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface lfx_frame_if;
    logic                        valid;
    logic                        ready;
    logic [lfx_pkg::COLOR_W-1:0] strip_color;
    logic                        refresh;

    modport source (output valid, output strip_color, output refresh, input ready);
    modport sink   (input valid, input strip_color, input refresh, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lfx_cfg_regs.sv
// APB configuration registers: effect mode, base color, speed.
// Depends on lfx_pkg.
`default_nettype none

module lfx_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lfx_pkg::APB_AW-1:0]  paddr,
    input  wire logic [lfx_pkg::APB_DW-1:0]  pwdata,
    output logic      [lfx_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output lfx_pkg::t_cfg                    o_cfg
);
    import lfx_pkg::*;

    logic [MODE_W-1:0]  r_mode;
    logic [COLOR_W-1:0] r_color;
    logic [SPEED_W-1:0] r_speed;
    logic [1:0]         reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write registers on the access phase; other indexes drop the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_color <= '0;
            r_speed <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:  r_mode  <= pwdata[MODE_W-1:0];
                REG_COLOR: r_color <= pwdata[COLOR_W-1:0];
                REG_SPEED: r_speed <= pwdata[SPEED_W-1:0];
                default:   ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_MODE:  prdata = APB_DW'(r_mode);
            REG_COLOR: prdata = APB_DW'(r_color);
            REG_SPEED: prdata = APB_DW'(r_speed);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.mode       = r_mode;
    assign o_cfg.base_color = r_color;
    assign o_cfg.speed      = r_speed;

endmodule

`default_nettype wire

>>> hw/rtl/lfx_effect_core.sv
// Tick timer and effect state (phase, fade triangle, color wheel).
// Produces the state after the current tick combinationally; depends on lfx_pkg.
`default_nettype none

module lfx_effect_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic           i_restart,
    input  lfx_pkg::t_cfg       i_cfg,
    output lfx_pkg::t_frame     o_frame
);
    import lfx_pkg::*;

    logic [TICK_W-1:0]  r_tick,  n_tick;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CH_W-1:0]    r_level, n_level;
    logic               r_rising, n_rising;
    logic [CH_W-1:0]    r_red,   n_red;
    logic [CH_W-1:0]    r_green, n_green;
    logic [CH_W-1:0]    r_blue,  n_blue;
    logic [SEG_W-1:0]   r_seg,   n_seg;
    logic [TICK_W-1:0]  period;
    logic [TICK_W-1:0]  tick_inc;
    logic               advance;
    logic               refresh;
    logic               rising_nx;

    assign period   = frame_period(i_cfg);
    assign tick_inc = r_tick + TICK_W'(1);

    // Next state for one tick
    always_comb begin
        n_tick    = r_tick;
        n_phase   = r_phase;
        n_level   = r_level;
        n_rising  = r_rising;
        n_red     = r_red;
        n_green   = r_green;
        n_blue    = r_blue;
        n_seg     = r_seg;
        advance   = 1'b0;
        refresh   = 1'b0;
        rising_nx = r_rising;

        if (i_restart) begin
            n_tick   = '0;
            n_phase  = '0;
            n_level  = '0;
            n_rising = 1'b0;
            n_red    = CH_MAX;
            n_green  = '0;
            n_blue   = '0;
            n_seg    = '0;
            refresh  = 1'b1;
        end else if (tick_inc >= period) begin
            n_tick  = '0;
            advance = 1'b1;
            refresh = 1'b1;
        end else begin
            n_tick = tick_inc;
        end

        // Step the effect at a frame boundary
        if (advance) begin
            case (i_cfg.mode)
                MODE_FLASH: begin
                    n_phase = (r_phase >= PHASE_W'(2)) ? '0 : r_phase + PHASE_W'(1);
                end
                MODE_STROBE: begin
                    n_phase = (r_phase == '0) ? PHASE_W'(1) : '0;
                end
                MODE_FADE: begin
                    if (r_level == CH_MAX) begin
                        rising_nx = 1'b0;
                    end else if (r_level == '0) begin
                        rising_nx = 1'b1;
                    end
                    n_rising = rising_nx;
                    n_level  = rising_nx ? r_level + CH_W'(1) : r_level - CH_W'(1);
                end
                MODE_SMOOTH: begin
                    case (r_seg)
                        3'd0: begin
                            n_green = r_green + CH_W'(1);
                            if (n_green == CH_MAX) n_seg = 3'd1;
                        end
                        3'd1: begin
                            n_red = r_red - CH_W'(1);
                            if (n_red == '0) n_seg = 3'd2;
                        end
                        3'd2: begin
                            n_blue = r_blue + CH_W'(1);
                            if (n_blue == CH_MAX) n_seg = 3'd3;
                        end
                        3'd3: begin
                            n_green = r_green - CH_W'(1);
                            if (n_green == '0) n_seg = 3'd4;
                        end
                        3'd4: begin
                            n_red = r_red + CH_W'(1);
                            if (n_red == CH_MAX) n_seg = 3'd5;
                        end
                        3'd5: begin
                            n_blue = r_blue - CH_W'(1);
                            if (n_blue == '0) n_seg = 3'd0;
                        end
                        default: n_seg = 3'd0;
                    endcase
                end
                default: ;
            endcase
        end

        // Unused modes keep the timer at zero and push nothing
        if (i_cfg.mode > MODE_SMOOTH) begin
            n_tick  = '0;
            refresh = 1'b0;
        end
    end

    // Commit state when a tick moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_phase  <= '0;
            r_level  <= '0;
            r_rising <= 1'b0;
            r_red    <= CH_MAX;
            r_green  <= '0;
            r_blue   <= '0;
            r_seg    <= '0;
        end else if (i_step) begin
            r_tick   <= n_tick;
            r_phase  <= n_phase;
            r_level  <= n_level;
            r_rising <= n_rising;
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_seg    <= n_seg;
        end
    end

    assign o_frame.phase       = n_phase;
    assign o_frame.fade_level  = n_level;
    assign o_frame.wheel_red   = n_red;
    assign o_frame.wheel_green = n_green;
    assign o_frame.wheel_blue  = n_blue;
    assign o_frame.refresh     = refresh;

endmodule

`default_nettype wire

>>> hw/rtl/lfx_color_map.sv
// Maps effect state to the strip color, including the fade scaling c*level/255.
// Depends on lfx_pkg.
`default_nettype none

module lfx_color_map (
    input  lfx_pkg::t_cfg                   i_cfg,
    input  lfx_pkg::t_frame                 i_frame,
    output logic [lfx_pkg::COLOR_W-1:0]     o_color
);
    import lfx_pkg::*;

    // floor(p/255) for a 16-bit product: (p + (p >> 8) + 1) >> 8
    function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] c,
                                                 input logic [CH_W-1:0] level);
        logic [15:0] p;
        logic [16:0] s;
        p = 16'(c) * 16'(level);
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    logic [COLOR_W-1:0] fade_color;

    assign fade_color = {scale_ch(i_cfg.base_color[23:16], i_frame.fade_level),
                         scale_ch(i_cfg.base_color[15:8],  i_frame.fade_level),
                         scale_ch(i_cfg.base_color[7:0],   i_frame.fade_level)};

    // Select the color for the active effect
    always_comb begin
        case (i_cfg.mode)
            MODE_CONTINUOUS: o_color = i_cfg.base_color;
            MODE_FLASH: begin
                if (i_frame.phase == PHASE_W'(1)) begin
                    o_color = COLOR_GREEN;
                end else if (i_frame.phase == PHASE_W'(2)) begin
                    o_color = COLOR_BLUE;
                end else begin
                    o_color = COLOR_RED;
                end
            end
            MODE_STROBE: o_color = (i_frame.phase == '0) ? i_cfg.base_color : COLOR_BLACK;
            MODE_FADE:   o_color = fade_color;
            MODE_SMOOTH: o_color = {i_frame.wheel_red, i_frame.wheel_green, i_frame.wheel_blue};
            default:     o_color = COLOR_BLACK;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/led_light_effect_generator.sv
// Top level of the LED light-effect generator: input register, effect core,
// color map and result register. Depends on lfx_pkg, lfx_ifs, lfx_cfg_regs,
// lfx_effect_core and lfx_color_map.
//
//   Port      Dir  Protocol     Payload
//   i_tick    in   valid/ready  restart
//   o_frame   out  valid/ready  strip_color[23:0], refresh
//   APB       in   APB r/w      effect_mode, base_color, speed_setting
//
// A tick transfers into one input register, then the core and color map compute
// its result in one pass into the result register, from which it transfers out.
// Throughput is one tick per cycle while the result is not stalled; the core commits
// its state as the tick moves from the input register to the result register.
// A stalled result holds both stages; the input register still takes a tick
// when the result register drains in the same cycle.
// Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none

module led_light_effect_generator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    lfx_tick_if.sink                         i_tick,
    lfx_frame_if.source                      o_frame,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lfx_pkg::APB_AW-1:0]  paddr,
    input  wire logic [lfx_pkg::APB_DW-1:0]  pwdata,
    output logic      [lfx_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import lfx_pkg::*;

    t_cfg               cfg;
    t_frame             frame;
    logic [COLOR_W-1:0] color;

    logic               r_s1_valid;
    logic               r_s1_restart;
    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_refresh;
    logic               s1_adv;
    logic               in_xfer;

    lfx_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfx_effect_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (s1_adv),
        .i_restart (r_s1_restart),
        .i_cfg     (cfg),
        .o_frame   (frame)
    );

    lfx_color_map u_map (
        .i_cfg   (cfg),
        .i_frame (frame),
        .o_color (color)
    );

    // Handshake: drain stage one when the result register is free or draining
    assign s1_adv       = r_s1_valid && (!r_out_valid || o_frame.ready);
    assign i_tick.ready = !r_s1_valid || s1_adv;
    assign in_xfer      = i_tick.valid && i_tick.ready;

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_s1_valid <= i_tick.valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_restart <= i_tick.restart;
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_color   <= color;
            r_out_refresh <= frame.refresh;
        end
    end

    assign o_frame.valid       = r_out_valid;
    assign o_frame.strip_color = r_out_color;
    assign o_frame.refresh     = r_out_refresh;

    // A restart in a live mode always pushes a frame
    a_restart_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_restart && (cfg.mode <= MODE_SMOOTH)) |=> r_out_refresh)
        else $error("restart did not push a frame");

    // A pending tick is never overwritten while stage one is held
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_restart)))
        else $error("held tick lost or changed");

    // A tick moving down always lands in the result register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("advanced tick produced no result");

    // Unused modes never push frames
    a_idle_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (cfg.mode > MODE_SMOOTH)) |=> !r_out_refresh)
        else $error("frame pushed in an unused mode");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for led_light_effect_generator: ticks in, strip frames out.
// Depends on lfx_pkg, lfx_ifs and the block's RTL; a local tracker predicts each frame.
`timescale 1ns / 1ps

module testbench;
    import lfx_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned REPORT_MAX   = 10;
    localparam logic [1:0]        REG_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd7;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               refresh;
    } t_strip_frame;

    // Tracks registers and effect state, and queues the frame each tick should give
    class effect_tracker;
        logic [MODE_W-1:0]  mode;
        logic [COLOR_W-1:0] color;
        logic [SPEED_W-1:0] speed;
        logic [TICK_W-1:0]  ticks;
        logic [PHASE_W-1:0] phase;
        logic [CH_W-1:0]    level;
        bit                 rising;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [SEG_W-1:0]   segment;
        t_strip_frame       pending[$];
        int unsigned        mismatches;

        function new();
            mode       = MODE_CONTINUOUS;
            color      = '0;
            speed      = '0;
            ticks      = '0;
            mismatches = 0;
            rewind();
        endfunction

        function void rewind();
            phase   = '0;
            level   = '0;
            rising  = 1'b0;
            red     = CH_MAX;
            green   = '0;
            blue    = '0;
            segment = '0;
        endfunction

        function void load_reg(logic [1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_MODE:  mode  = value[MODE_W-1:0];
                REG_COLOR: color = value[COLOR_W-1:0];
                REG_SPEED: speed = value[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_tick(bit restart);
            int           base;
            int           period;
            logic [31:0]  r_ch;
            logic [31:0]  g_ch;
            logic [31:0]  b_ch;
            t_strip_frame f;
            // Frame period in ticks, floored at one
            base = (int'(speed) * 10 >= 1000) ? 0 : 1000 - int'(speed) * 10;
            case (mode)
                MODE_CONTINUOUS: period = 1000;
                MODE_FADE:       period = base / 50;
                MODE_SMOOTH:     period = base / 8;
                default:         period = base;
            endcase
            if (period == 0) begin
                period = 1;
            end
            f.refresh = 1'b0;
            if (restart) begin
                rewind();
                ticks     = '0;
                f.refresh = 1'b1;
            end else begin
                ticks = ticks + 1'b1;
                if (int'(ticks) >= period) begin
                    ticks     = '0;
                    f.refresh = 1'b1;
                    // Advance the effect by one frame
                    case (mode)
                        MODE_FLASH:  phase = (phase >= 2'd2) ? 2'd0 : phase + 1'b1;
                        MODE_STROBE: phase = (phase == 2'd0) ? 2'd1 : 2'd0;
                        MODE_FADE: begin
                            if (level == CH_MAX) begin
                                rising = 1'b0;
                            end else if (level == '0) begin
                                rising = 1'b1;
                            end
                            level = rising ? level + 1'b1 : level - 1'b1;
                        end
                        MODE_SMOOTH: begin
                            case (segment)
                                3'd0: begin
                                    green = green + 1'b1;
                                    if (green == CH_MAX) segment = 3'd1;
                                end
                                3'd1: begin
                                    red = red - 1'b1;
                                    if (red == '0) segment = 3'd2;
                                end
                                3'd2: begin
                                    blue = blue + 1'b1;
                                    if (blue == CH_MAX) segment = 3'd3;
                                end
                                3'd3: begin
                                    green = green - 1'b1;
                                    if (green == '0) segment = 3'd4;
                                end
                                3'd4: begin
                                    red = red + 1'b1;
                                    if (red == CH_MAX) segment = 3'd5;
                                end
                                3'd5: begin
                                    blue = blue - 1'b1;
                                    if (blue == '0) segment = 3'd0;
                                end
                                default: segment = 3'd0;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            // Unused modes keep the counter at zero and push nothing
            if (mode > MODE_SMOOTH) begin
                ticks     = '0;
                f.refresh = 1'b0;
            end
            case (mode)
                MODE_CONTINUOUS: f.color = color;
                MODE_FLASH: begin
                    if (phase == 2'd1)      f.color = COLOR_GREEN;
                    else if (phase == 2'd2) f.color = COLOR_BLUE;
                    else                    f.color = COLOR_RED;
                end
                MODE_STROBE: f.color = (phase == 2'd0) ? color : COLOR_BLACK;
                MODE_FADE: begin
                    r_ch = (32'(color[23:16]) * 32'(level)) / 32'd255;
                    g_ch = (32'(color[15:8]) * 32'(level)) / 32'd255;
                    b_ch = (32'(color[7:0]) * 32'(level)) / 32'd255;
                    f.color = {r_ch[7:0], g_ch[7:0], b_ch[7:0]};
                end
                MODE_SMOOTH: f.color = {red, green, blue};
                default:     f.color = COLOR_BLACK;
            endcase
            pending.push_back(f);
        endfunction

        function void match_frame(logic [COLOR_W-1:0] got_color, logic got_refresh);
            t_strip_frame want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("frame with none expected: color %06h refresh %0b",
                             got_color, got_refresh);
                end
                return;
            end
            want = pending.pop_front();
            if (want.color !== got_color || want.refresh !== got_refresh) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("frame mismatch: color exp %06h got %06h, refresh exp %0b got %0b",
                             want.color, got_color, want.refresh, got_refresh);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int unsigned         gap_pct;
    int unsigned         stall_pct;
    int unsigned         cycles = 0;
    effect_tracker       tracker = new();

    lfx_tick_if  tick_ch ();
    lfx_frame_if frame_ch ();

    led_light_effect_generator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_ch),
        .o_frame (frame_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Stall the frame output at random
    always @(negedge i_clk) begin
        frame_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every frame transfer
    always @(posedge i_clk) begin
        if (i_rst_n && frame_ch.valid && frame_ch.ready) begin
            tracker.match_frame(frame_ch.strip_color, frame_ch.refresh);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_tick(bit restart);
        while ($urandom_range(99) < gap_pct) begin
            tick_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        tick_ch.valid   = 1'b1;
        tick_ch.restart = restart;
        do @(posedge i_clk); while (!tick_ch.ready);
        tracker.take_tick(restart);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.load_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Hold off new ticks until every queued frame has come out
    task automatic drain_frames();
        tick_ch.valid = 1'b0;
        while (tracker.pending.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Drain, reprogram all registers, pick an idling profile
    task automatic start_phase(logic [MODE_W-1:0] mode, logic [COLOR_W-1:0] color,
                               logic [SPEED_W-1:0] speed, int unsigned profile);
        drain_frames();
        write_reg(REG_MODE, APB_DW'(mode));
        write_reg(REG_COLOR, APB_DW'(color));
        write_reg(REG_SPEED, APB_DW'(speed));
        case (profile % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 55; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 55; end
            default: begin gap_pct = 30; stall_pct = 30; end
        endcase
    endtask

    task automatic run_ticks(int unsigned count, int unsigned restart_pct);
        for (int unsigned i = 0; i < count; i++) begin
            if (i == count / 2) begin
                drain_frames();
            end
            send_tick($urandom_range(99) < restart_pct);
        end
    endtask

    initial begin
        tick_ch.valid   = 1'b0;
        tick_ch.restart = 1'b0;
        frame_ch.ready  = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        gap_pct         = 0;
        stall_pct       = 0;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // No refresh before the first restart, then a restart pushes one
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);

        // Flash at a one-tick period walks red, green, blue and wraps
        start_phase(MODE_FLASH, 24'hFFFFFF, 7'd127, 1);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);

        // Strobe entered with a nonzero phase steps back to phase zero first
        start_phase(MODE_STROBE, 24'hFFFFFF, 7'd100, 2);
        repeat (3) send_tick(1'b0);

        // Fade ramps up from zero
        start_phase(MODE_FADE, 24'h80FF01, 7'd100, 3);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // Wheel starts from pure red
        start_phase(MODE_SMOOTH, 24'h000000, 7'd127, 0);
        repeat (2) send_tick(1'b0);

        // Unused mode stays dark, even on restart; unmapped register is ignored
        start_phase(MODE_OFF, 24'h000000, 7'd0, 1);
        write_reg(REG_UNUSED, '1);
        send_tick(1'b0);
        send_tick(1'b1);

        start_phase(MODE_CONTINUOUS, 24'h123456, 7'd0, 2);
        send_tick(1'b0);

        // Long period, then a short one that the counter already exceeds
        start_phase(MODE_FLASH, 24'($urandom), 7'd0, 0);
        run_ticks(80, 0);
        start_phase(MODE_FLASH, 24'($urandom), 7'd99, 1);
        run_ticks(60, 2);
        start_phase(MODE_STROBE, 24'($urandom), 7'($urandom_range(90, 127)), 2);
        run_ticks(50, 5);

        // Fade through the peak and back down
        start_phase(MODE_FADE, 24'hFFFFFF, 7'd99, 3);
        send_tick(1'b1);
        run_ticks(280, 0);
        start_phase(MODE_FADE, 24'($urandom), 7'd0, 0);
        run_ticks(80, 3);

        // Walk the wheel across several segments and idling profiles
        start_phase(MODE_SMOOTH, 24'($urandom), 7'd127, 1);
        send_tick(1'b1);
        run_ticks(250, 0);
        start_phase(MODE_SMOOTH, 24'($urandom), 7'd99, 2);
        run_ticks(250, 0);
        start_phase(MODE_SMOOTH, 24'($urandom), 7'd100, 3);
        run_ticks(250, 0);

        // Mixed settings with occasional restarts
        for (int unsigned k = 0; k < 10; k++) begin
            start_phase(MODE_W'($urandom_range(7)), 24'($urandom),
                        7'($urandom_range(127)), k);
            run_ticks(24, 4);
        end

        drain_frames();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
